### rtl/teq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package teq_pkg;

   localparam int TIME_W              = 32;
   localparam int ID_W                = 16;
   localparam int COUNT_W             = 32;
   localparam int OCC_W               = 5;
   localparam int DEFAULT_QUEUE_DEPTH = 16;
   localparam int MAX_BATCH           = 16;
   localparam int BATCH_W             = $clog2(MAX_BATCH);

   typedef enum logic [1:0] {
      STATUS_SCHEDULED  = 2'd0,
      STATUS_DROPPED    = 2'd1,
      STATUS_DISPATCHED = 2'd2,
      STATUS_EMPTY      = 2'd3
   } status_type;

   typedef enum logic {
      ACTION_SCHEDULE = 1'b0,
      ACTION_STEP     = 1'b1
   } action_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;    // capture the accepted word
      logic insert;  // sorted insert of the held event
      logic drop;    // report queue full
      logic pop;     // dispatch the head entry
      logic empty;   // report empty queue
      logic last;    // mark the result as final
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic full;
      logic empty;
      logic next_equal;  // entry behind the head has the head's time
   } stat_type;

endpackage

`default_nettype wire

### rtl/teq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module teq_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic             req_action,
   input  wire teq_pkg::stat_type stat,
   output teq_pkg::cmd_type      cmd,
   output logic                  busy
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCHED,
      ST_STEP
   } state_type;

   state_type                     state_ff, state_in;
   logic [teq_pkg::BATCH_W-1:0]   batch_ff, batch_in;
   logic                          busy_ff, busy_in;
   logic                          more;

   // keep dispatching while the next entry shares the head time, up to MAX_BATCH per step word
   assign more = stat.next_equal && (batch_ff != teq_pkg::BATCH_W'(teq_pkg::MAX_BATCH - 1));

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      batch_in = batch_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               batch_in = '0;
               state_in = (req_action == teq_pkg::ACTION_STEP) ? ST_STEP : ST_SCHED;
            end
         end
         ST_SCHED: begin
            cmd.last = 1'b1;
            if (stat.full) begin
               cmd.drop = 1'b1;
            end else begin
               cmd.insert = 1'b1;
            end
            state_in = ST_IDLE;
         end
         ST_STEP: begin
            if (stat.empty) begin
               cmd.empty = 1'b1;
               cmd.last  = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               cmd.pop  = 1'b1;
               cmd.last = !more;
               if (more) begin
                  batch_in = batch_ff + 1'b1;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      busy_in = (state_in != ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         batch_ff <= '0;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         batch_ff <= batch_in;
         busy_ff  <= busy_in;
      end
   end

   assign busy = busy_ff;

endmodule

`default_nettype wire

### rtl/teq_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module teq_dpath #(
   parameter int QUEUE_DEPTH = teq_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire teq_pkg::cmd_type              cmd,
   input  wire logic [teq_pkg::TIME_W-1:0]    req_event_time,
   input  wire logic [teq_pkg::ID_W-1:0]      req_event_id,
   output teq_pkg::stat_type                  stat,
   output logic                               rsp_valid,
   output logic [1:0]                         rsp_status,
   output logic [teq_pkg::ID_W-1:0]           rsp_out_event_id,
   output logic [teq_pkg::TIME_W-1:0]         rsp_sim_time,
   output logic [teq_pkg::COUNT_W-1:0]        rsp_dispatched_count,
   output logic [teq_pkg::OCC_W-1:0]          rsp_occupancy,
   output logic                               rsp_last
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   // sorted entry cells, head at index 0
   logic [teq_pkg::TIME_W-1:0]  time_ff [QUEUE_DEPTH];
   logic [teq_pkg::ID_W-1:0]    id_ff   [QUEUE_DEPTH];
   logic [teq_pkg::TIME_W-1:0]  ins_time_in [QUEUE_DEPTH];
   logic [teq_pkg::ID_W-1:0]    ins_id_in   [QUEUE_DEPTH];
   logic [teq_pkg::TIME_W-1:0]  pop_time_in [QUEUE_DEPTH];
   logic [teq_pkg::ID_W-1:0]    pop_id_in   [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]      later;

   logic [teq_pkg::TIME_W-1:0]  item_time_ff;
   logic [teq_pkg::ID_W-1:0]    item_id_ff;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [teq_pkg::TIME_W-1:0]  now_ff, now_in;
   logic [teq_pkg::COUNT_W-1:0] total_ff, total_in;
   logic [31:0]                 count_wide;

   logic                        rsp_valid_ff;
   logic [1:0]                  rsp_status_ff;
   logic [teq_pkg::ID_W-1:0]    rsp_id_ff;
   logic [teq_pkg::TIME_W-1:0]  rsp_time_ff;
   logic [teq_pkg::COUNT_W-1:0] rsp_total_ff;
   logic [teq_pkg::OCC_W-1:0]   rsp_occ_ff;
   logic                        rsp_last_ff;

   // parallel compare: which live entries lie strictly after the new event
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         later[i] = (CNT_W'(i) < count_ff) && (time_ff[i] > item_time_ff);
      end
   end

   genvar g;
   generate
      for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
         logic shift_up;
         logic take_new;
         if (g == 0) begin : g_head
            assign shift_up = 1'b0;
         end else begin : g_body
            assign shift_up = later[g-1];
         end
         assign take_new = later[g] || (CNT_W'(g) == count_ff);

         always_comb begin
            if (shift_up) begin
               ins_time_in[g] = time_ff[(g == 0) ? 0 : g-1];
               ins_id_in[g]   = id_ff[(g == 0) ? 0 : g-1];
            end else if (take_new) begin
               ins_time_in[g] = item_time_ff;
               ins_id_in[g]   = item_id_ff;
            end else begin
               ins_time_in[g] = time_ff[g];
               ins_id_in[g]   = id_ff[g];
            end
         end

         if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign pop_time_in[g] = time_ff[g];
            assign pop_id_in[g]   = id_ff[g];
         end else begin : g_inner
            assign pop_time_in[g] = time_ff[g+1];
            assign pop_id_in[g]   = id_ff[g+1];
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            time_ff[i] <= ins_time_in[i];
            id_ff[i]   <= ins_id_in[i];
         end
      end else if (cmd.pop) begin
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            time_ff[i] <= pop_time_in[i];
            id_ff[i]   <= pop_id_in[i];
         end
      end
      if (cmd.load) begin
         item_time_ff <= req_event_time;
         item_id_ff   <= req_event_id;
      end
   end

   always_comb begin
      count_in = count_ff;
      now_in   = now_ff;
      total_in = total_ff;
      if (cmd.insert) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.pop) begin
         count_in = count_ff - 1'b1;
         now_in   = time_ff[0];
         total_in = total_ff + 1'b1;
      end
   end

   assign count_wide = 32'(count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         now_ff       <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         now_ff       <= now_in;
         total_ff     <= total_in;
         rsp_valid_ff <= cmd.insert || cmd.drop || cmd.pop || cmd.empty;
      end
   end

   // result word, registered; payload needs no reset
   always_ff @(posedge clock) begin
      priority if (cmd.pop) begin
         rsp_status_ff <= teq_pkg::STATUS_DISPATCHED;
         rsp_id_ff     <= id_ff[0];
      end else if (cmd.insert) begin
         rsp_status_ff <= teq_pkg::STATUS_SCHEDULED;
         rsp_id_ff     <= '0;
      end else if (cmd.drop) begin
         rsp_status_ff <= teq_pkg::STATUS_DROPPED;
         rsp_id_ff     <= '0;
      end else begin
         rsp_status_ff <= teq_pkg::STATUS_EMPTY;
         rsp_id_ff     <= '0;
      end
      rsp_time_ff  <= now_in;
      rsp_total_ff <= total_in;
      rsp_occ_ff   <= count_wide[teq_pkg::OCC_W-1:0];
      rsp_last_ff  <= cmd.last;
   end

   assign stat.full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign stat.empty      = (count_ff == '0);
   assign stat.next_equal = (count_ff >= CNT_W'(2)) && (time_ff[1] == time_ff[0]);

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_out_event_id     = rsp_id_ff;
   assign rsp_sim_time         = rsp_time_ff;
   assign rsp_dispatched_count = rsp_total_ff;
   assign rsp_occupancy        = rsp_occ_ff;
   assign rsp_last             = rsp_last_ff;

endmodule

`default_nettype wire

### rtl/timestamp_ordered_event_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                                               Handshake
// request   req_action, req_event_time, req_event_id            word taken when start & !busy
// response  rsp_status, rsp_out_event_id, rsp_sim_time,         one cycle, rsp_valid strobe
//           rsp_dispatched_count, rsp_occupancy, rsp_last
//
// A schedule word is first captured, then placed by the parallel compare and shift
// insert across all entry cells. A step word pops a batch of up to MAX_BATCH
// equal-time events (one empty report on an empty queue), one head pop per cycle.
// Each result is registered and appears in the cycle after the cycle that produced it.
// Synchronous reset empties the queue and clears time and dispatch count; entry
// contents are left as they are. The receiver cannot stall results.

module timestamp_ordered_event_queue #(
   parameter int QUEUE_DEPTH = teq_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_action,
   input  wire logic [teq_pkg::TIME_W-1:0]    req_event_time,
   input  wire logic [teq_pkg::ID_W-1:0]      req_event_id,
   output logic                               rsp_valid,
   output logic [1:0]                         rsp_status,
   output logic [teq_pkg::ID_W-1:0]           rsp_out_event_id,
   output logic [teq_pkg::TIME_W-1:0]         rsp_sim_time,
   output logic [teq_pkg::COUNT_W-1:0]        rsp_dispatched_count,
   output logic [teq_pkg::OCC_W-1:0]          rsp_occupancy,
   output logic                               rsp_last
);

   teq_pkg::cmd_type  cmd;
   teq_pkg::stat_type stat;
   logic              accept;

   // controller sees the word only when it is actually taken
   assign accept = start && !busy;

   // sequence schedule, drop, dispatch batch and empty report
   teq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (accept),
      .req_action (req_action),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy)
   );

   // hold sorted entries, simulation time, dispatch count and the result word
   teq_dpath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .req_event_time       (req_event_time),
      .req_event_id         (req_event_id),
      .stat                 (stat),
      .rsp_valid            (rsp_valid),
      .rsp_status           (rsp_status),
      .rsp_out_event_id     (rsp_out_event_id),
      .rsp_sim_time         (rsp_sim_time),
      .rsp_dispatched_count (rsp_dispatched_count),
      .rsp_occupancy        (rsp_occupancy),
      .rsp_last             (rsp_last)
   );

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int TIME_W         = teq_pkg::TIME_W;
   localparam int ID_W           = teq_pkg::ID_W;
   localparam int COUNT_W        = teq_pkg::COUNT_W;
   localparam int OCC_W          = teq_pkg::OCC_W;
   localparam int MAX_BATCH      = teq_pkg::MAX_BATCH;
   localparam int QUEUE_DEPTH    = teq_pkg::DEFAULT_QUEUE_DEPTH;
   localparam int RESET_CYCLES   = 5;
   localparam int RANDOM_WORDS   = 500;
   localparam int CALM_TAIL      = 80;    // final words sent back to back
   localparam int DRAIN_CYCLES   = 20;    // quiet time after the last expected result
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word taken and no result
   localparam int REPORT_LIMIT   = 10;
   localparam int DIRECTED_ROWS  = 26;

   // One pending event as the predictor keeps it.
   typedef struct packed {
      logic [TIME_W-1:0] stamp;
      logic [ID_W-1:0]   id;
   } pending_event_type;

   // One result word, in the order of the response ports.
   typedef struct packed {
      teq_pkg::status_type status;
      logic [ID_W-1:0]     id;
      logic [TIME_W-1:0]   sim_time;
      logic [COUNT_W-1:0]  count;
      logic [OCC_W-1:0]    occupancy;
      logic                last;
   } result_word_type;

   // One row of the directed table. Where typed is set, status and out id of the
   // single result come from the row; the rest of the word from the predictor.
   typedef struct packed {
      teq_pkg::action_type action;
      logic [TIME_W-1:0]   stamp;
      logic [ID_W-1:0]     id;
      logic                typed;
      teq_pkg::status_type status;
      logic [ID_W-1:0]     out_id;
   } directed_row_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               start;
   logic               busy;
   logic               req_action;
   logic [TIME_W-1:0]  req_event_time;
   logic [ID_W-1:0]    req_event_id;
   logic               rsp_valid;
   logic [1:0]         rsp_status;
   logic [ID_W-1:0]    rsp_out_event_id;
   logic [TIME_W-1:0]  rsp_sim_time;
   logic [COUNT_W-1:0] rsp_dispatched_count;
   logic [OCC_W-1:0]   rsp_occupancy;
   logic               rsp_last;

   // Predictor state: sorted pending events, simulation time, dispatch total.
   pending_event_type  pending_events[$];
   logic [TIME_W-1:0]  sim_now;
   logic [COUNT_W-1:0] dispatch_total;

   // Result words still owed by the block, oldest first.
   result_word_type    expected_results[$];

   int                 failures = 0;
   int                 stall_cycles = 0;

   timestamp_ordered_event_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) uut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_action          (req_action),
      .req_event_time      (req_event_time),
      .req_event_id        (req_event_id),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_out_event_id    (rsp_out_event_id),
      .rsp_sim_time        (rsp_sim_time),
      .rsp_dispatched_count(rsp_dispatched_count),
      .rsp_occupancy       (rsp_occupancy),
      .rsp_last            (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Directed table: extremes first, then a time behind the simulation time,
   // then a full queue of equal times (FIFO ties, drop, longest batch).
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{teq_pkg::ACTION_STEP, 32'h0, 16'h0000, 1'b1, teq_pkg::STATUS_EMPTY, 16'h0000},
      '{teq_pkg::ACTION_SCHEDULE, 32'hFFFFFFFF, 16'hFFFF, 1'b1, teq_pkg::STATUS_SCHEDULED,
        16'h0000},
      '{teq_pkg::ACTION_SCHEDULE, 32'h0, 16'h0000, 1'b1, teq_pkg::STATUS_SCHEDULED, 16'h0000},
      '{teq_pkg::ACTION_STEP, 32'h0, 16'h0000, 1'b1, teq_pkg::STATUS_DISPATCHED, 16'h0000},
      '{teq_pkg::ACTION_STEP, 32'h0, 16'h0000, 1'b1, teq_pkg::STATUS_DISPATCHED, 16'hFFFF},
      '{teq_pkg::ACTION_SCHEDULE, 32'h5, 16'hAAAA, 1'b1, teq_pkg::STATUS_SCHEDULED, 16'h0000},
      '{teq_pkg::ACTION_STEP, 32'h0, 16'h0000, 1'b1, teq_pkg::STATUS_DISPATCHED, 16'hAAAA},
      '{teq_pkg::ACTION_SCHEDULE, 32'h64, 16'h0001, 1'b1, teq_pkg::STATUS_SCHEDULED, 16'h0000},
      '{teq_pkg::ACTION_SCHEDULE, 32'h64, 16'h0002, 1'b1, teq_pkg::STATUS_SCHEDULED, 16'h0000},
      '{teq_pkg::ACTION_SCHEDULE, 32'h64, 16'h0003, 1'b1, teq_pkg::STATUS_SCHEDULED, 16'h0000},
      '{teq_pkg::ACTION_SCHEDULE, 32'h64, 16'h0004, 1'b1, teq_pkg::STATUS_SCHEDULED, 16'h0000},
      '{teq_pkg::ACTION_SCHEDULE, 32'h64, 16'h0005, 1'b1, teq_pkg::STATUS_SCHEDULED, 16'h0000},
      '{teq_pkg::ACTION_SCHEDULE, 32'h64, 16'h0006, 1'b1, teq_pkg::STATUS_SCHEDULED, 16'h0000},
      '{teq_pkg::ACTION_SCHEDULE, 32'h64, 16'h0007, 1'b1, teq_pkg::STATUS_SCHEDULED, 16'h0000},
      '{teq_pkg::ACTION_SCHEDULE, 32'h64, 16'h0008, 1'b1, teq_pkg::STATUS_SCHEDULED, 16'h0000},
      '{teq_pkg::ACTION_SCHEDULE, 32'h64, 16'h0009, 1'b1, teq_pkg::STATUS_SCHEDULED, 16'h0000},
      '{teq_pkg::ACTION_SCHEDULE, 32'h64, 16'h000A, 1'b1, teq_pkg::STATUS_SCHEDULED, 16'h0000},
      '{teq_pkg::ACTION_SCHEDULE, 32'h64, 16'h000B, 1'b1, teq_pkg::STATUS_SCHEDULED, 16'h0000},
      '{teq_pkg::ACTION_SCHEDULE, 32'h64, 16'h000C, 1'b1, teq_pkg::STATUS_SCHEDULED, 16'h0000},
      '{teq_pkg::ACTION_SCHEDULE, 32'h64, 16'h000D, 1'b1, teq_pkg::STATUS_SCHEDULED, 16'h0000},
      '{teq_pkg::ACTION_SCHEDULE, 32'h64, 16'h000E, 1'b1, teq_pkg::STATUS_SCHEDULED, 16'h0000},
      '{teq_pkg::ACTION_SCHEDULE, 32'h64, 16'h000F, 1'b1, teq_pkg::STATUS_SCHEDULED, 16'h0000},
      '{teq_pkg::ACTION_SCHEDULE, 32'h64, 16'h0010, 1'b1, teq_pkg::STATUS_SCHEDULED, 16'h0000},
      '{teq_pkg::ACTION_SCHEDULE, 32'h0, 16'h5555, 1'b1, teq_pkg::STATUS_DROPPED, 16'h0000},
      '{teq_pkg::ACTION_STEP, 32'h0, 16'h0000, 1'b0, teq_pkg::STATUS_DISPATCHED, 16'h0000},
      '{teq_pkg::ACTION_STEP, 32'h0, 16'h0000, 1'b1, teq_pkg::STATUS_EMPTY, 16'h0000}
   };

   // Queue one expected result word built from the current predictor state.
   task automatic push_result(input teq_pkg::status_type status, input logic [ID_W-1:0] id,
                              input logic last);
      result_word_type word;
      word.status    = status;
      word.id        = id;
      word.sim_time  = sim_now;
      word.count     = dispatch_total;
      word.occupancy = OCC_W'(pending_events.size());
      word.last      = last;
      expected_results.push_back(word);
   endtask

   // Advance the predictor by one accepted word and queue the results it owes.
   task automatic predict_results(input teq_pkg::action_type act,
                                  input logic [TIME_W-1:0] stamp,
                                  input logic [ID_W-1:0] id);
      pending_event_type ev;
      int                pos;
      int                n;
      bit                more;
      if (act == teq_pkg::ACTION_SCHEDULE) begin
         if (pending_events.size() >= QUEUE_DEPTH) begin
            push_result(teq_pkg::STATUS_DROPPED, '0, 1'b1);
         end else begin
            // insert behind every entry with an equal or earlier time
            pos = pending_events.size();
            for (int i = 0; i < pending_events.size(); i++) begin
               if (pending_events[i].stamp > stamp) begin
                  pos = i;
                  break;
               end
            end
            ev.stamp = stamp;
            ev.id    = id;
            pending_events.insert(pos, ev);
            push_result(teq_pkg::STATUS_SCHEDULED, '0, 1'b1);
         end
      end else if (pending_events.size() == 0) begin
         push_result(teq_pkg::STATUS_EMPTY, '0, 1'b1);
      end else begin
         // take the head, then every entry sharing its time, up to one batch
         n = 0;
         do begin
            ev             = pending_events[0];
            pending_events.delete(0);
            sim_now        = ev.stamp;
            dispatch_total = dispatch_total + 1'b1;
            more = (pending_events.size() > 0) && (pending_events[0].stamp == sim_now) &&
                   (n + 1 < MAX_BATCH);
            push_result(teq_pkg::STATUS_DISPATCHED, ev.id, !more);
            n++;
         end while (more);
      end
   endtask

   // Present one word from a falling edge and hold it until the block takes it.
   // Leave start high on return so back-to-back words never toggle it.
   task automatic send_word(input teq_pkg::action_type act, input logic [TIME_W-1:0] stamp,
                            input logic [ID_W-1:0] id, input bit idle_ok,
                            input bit typed, input teq_pkg::status_type typed_status,
                            input logic [ID_W-1:0] typed_id);
      int              gap;
      result_word_type word;
      gap = 0;
      if (idle_ok && $urandom_range(0, 3) == 0)
         gap = $urandom_range(1, 8);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start          <= 1'b1;
      req_action     <= act;
      req_event_time <= stamp;
      req_event_id   <= id;
      do @(posedge clock); while (busy);
      predict_results(act, stamp, id);
      // take status and out id of a typed row from the table, not the predictor
      if (typed) begin
         word        = expected_results[$];
         word.status = typed_status;
         word.id     = typed_id;
         expected_results[$] = word;
      end
      @(negedge clock);
   endtask

   task automatic flag_failure(input string msg);
      failures++;
      if (failures <= REPORT_LIMIT)
         $display("ERROR at %0t: %s", $time, msg);
   endtask

   // Check every result word against the oldest expectation.
   always @(posedge clock) begin : check_results
      result_word_type want;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            flag_failure($sformatf("result with nothing expected: status %0d id %h",
                                   rsp_status, rsp_out_event_id));
         end else begin
            want = expected_results[0];
            expected_results.delete(0);
            if (rsp_status !== want.status || rsp_out_event_id !== want.id ||
                rsp_sim_time !== want.sim_time || rsp_dispatched_count !== want.count ||
                rsp_occupancy !== want.occupancy || rsp_last !== want.last)
               flag_failure($sformatf({"expected st %0d id %h t %h cnt %0d occ %0d last %b, ",
                                       "got st %0d id %h t %h cnt %0d occ %0d last %b"},
                                      want.status, want.id, want.sim_time, want.count,
                                      want.occupancy, want.last, rsp_status,
                                      rsp_out_event_id, rsp_sim_time,
                                      rsp_dispatched_count, rsp_occupancy, rsp_last));
         end
      end
   end

   // Stop a hung run: count cycles in which no word is taken and no result shows.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      int                  k;
      int                  phase_left;
      bit                  filling;
      bit                  calm;
      teq_pkg::action_type act;
      logic [TIME_W-1:0]   stamp;
      logic [TIME_W-1:0]   near;
      logic [ID_W-1:0]     id;

      // hold every input at a known value through reset
      reset          = 1'b1;
      start          = 1'b0;
      req_action     = teq_pkg::ACTION_SCHEDULE;
      req_event_time = '0;
      req_event_id   = '0;
      sim_now        = '0;
      dispatch_total = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (k = 0; k < DIRECTED_ROWS; k++)
         send_word(directed_rows[k].action, directed_rows[k].stamp, directed_rows[k].id,
                   1'b1, directed_rows[k].typed, directed_rows[k].status,
                   directed_rows[k].out_id);

      // Random part: alternate fill phases (mostly schedules, so the queue runs
      // full and drops) with drain phases (mostly steps, so batches and empty
      // steps come up). Most times sit on or just after an existing entry to build ties.
      filling    = 1'b0;
      calm       = 1'b0;
      phase_left = 0;
      for (k = 0; k < RANDOM_WORDS; k++) begin
         if (phase_left == 0) begin
            filling    = !filling;
            phase_left = $urandom_range(4, 40);
            calm       = ($urandom_range(0, 2) == 0);
         end
         phase_left--;
         act = ($urandom_range(0, 99) < (filling ? 15 : 70)) ? teq_pkg::ACTION_STEP :
                                                               teq_pkg::ACTION_SCHEDULE;
         near = (pending_events.size() > 0) ?
                pending_events[$urandom_range(0, pending_events.size() - 1)].stamp : sim_now;
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: stamp = near + $urandom_range(0, 2);
            6, 7:             stamp = $urandom();
            8:                stamp = sim_now - $urandom_range(1, 3);
            default:          stamp = $urandom_range(0, 1) ? '1 : '0;
         endcase
         id = ID_W'($urandom_range(0, 65535));
         send_word(act, stamp, id, !calm && (k < RANDOM_WORDS - CALM_TAIL),
                   1'b0, teq_pkg::STATUS_SCHEDULED, '0);
      end
      start <= 1'b0;

      // wait out every owed result, then watch for strays
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
